### design/drive_command_can_framer_defines.svh
// ----------------------------------------------------------------------------
// drive command can framer assertion macros
// shared property shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef DRIVE_COMMAND_CAN_FRAMER_DEFINES_SVH
`define DRIVE_COMMAND_CAN_FRAMER_DEFINES_SVH

// same-cycle implication, quiet during reset
`define DCCF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("dccf check failed");

// next-cycle implication, quiet during reset
`define DCCF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("dccf check failed");

`endif

### design/dccf_pkg.sv
// ----------------------------------------------------------------------------
// dccf_pkg
// constants and types shared by the drive command can framer
// ----------------------------------------------------------------------------
`default_nettype none

package dccf_pkg;

    localparam int FILTER_FRAC_BITS = 16;

    localparam logic [10:0] MODE_ID   = 11'h156;
    localparam logic [10:0] VALUE_ID  = 11'h157;
    localparam logic [3:0]  MODE_LEN  = 4'd8;
    localparam logic [3:0]  VALUE_LEN = 4'd5;

    localparam logic [15:0]        ALPHA_RESET     = 16'd7316;
    localparam logic signed [10:0] ACCEL_MAX_RESET = 11'sd100;
    localparam logic signed [10:0] ACCEL_MIN_RESET = -11'sd300;
    localparam logic [7:0]         SPEED_LVL_RESET = 8'd200;

    // accel offset carried in the value frame
    localparam logic [15:0] ACCEL_OFFSET = 16'd1023;

    typedef enum logic [1:0] {
        REG_FILTER_ALPHA = 2'd0,
        REG_ACCEL_MAX    = 2'd1,
        REG_ACCEL_MIN    = 2'd2,
        REG_SPEED_LEVEL  = 2'd3
    } reg_idx_t;

    // held fields of the frame pair
    typedef struct packed {
        logic       remote;
        logic [7:0] speed_level;
        logic [7:0] gear_ind;
        logic [7:0] alive;
        logic [15:0] accel16;
    } frame_pair_t;

endpackage

`default_nettype wire

### design/dccf_lpf.sv
// ----------------------------------------------------------------------------
// dccf_lpf
// first-order steering low-pass filter, one update per load, with the
// truncated angle times ten taken from the held filter value
// ----------------------------------------------------------------------------
`default_nettype none

module dccf_lpf #(
    parameter int FRAC_BITS = dccf_pkg::FILTER_FRAC_BITS
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               load,
    input  wire logic signed [10:0] steering_deg,
    input  wire logic [15:0]        filter_alpha,
    output logic [15:0]             steer_x10
);

    localparam int XW = 11 + FRAC_BITS;
    localparam int DW = ((XW > 32) ? XW : 32) + 1;
    localparam int PW = DW + 17;
    localparam int SW = PW - 15;

    logic signed [31:0]   y_reg;
    logic signed [31:0]   y_next;
    logic signed [DW-1:0] x_ext;
    logic signed [DW-1:0] y_ext;
    logic signed [DW-1:0] diff;
    logic signed [16:0]   alpha_s;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] prod_sh;
    logic signed [SW-1:0] sum;
    logic                 ovf;
    logic signed [31:0]   q;
    logic                 corr;
    logic [15:0]          q16;

    assign x_ext   = $signed({{(DW-11){steering_deg[10]}}, steering_deg}) <<< FRAC_BITS;
    assign y_ext   = $signed({{(DW-32){y_reg[31]}}, y_reg});
    assign diff    = x_ext - y_ext;
    assign alpha_s = $signed({1'b0, filter_alpha});
    assign prod    = alpha_s * diff;
    // arithmetic shift rounds toward minus infinity
    assign prod_sh = prod >>> 16;
    assign sum     = $signed({{(SW-32){y_reg[31]}}, y_reg}) + prod_sh[SW-1:0];

    // overflow when the bits above 31 do not all copy the sign
    assign ovf = (sum[SW-1:31] != {(SW-31){sum[SW-1]}});

    always_comb begin
        if (ovf) begin
            y_next = sum[SW-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            y_next = sum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_reg <= '0;
        end else if (load) begin
            y_reg <= y_next;
        end
    end

    // truncate toward zero, then times ten in 16 bits
    assign q    = y_reg >>> FRAC_BITS;
    assign corr = y_reg[31] && (|y_reg[FRAC_BITS-1:0]);
    assign q16  = q[15:0] + {15'd0, corr};
    assign steer_x10 = (q16 << 3) + (q16 << 1);

endmodule

`default_nettype wire

### design/drive_command_can_framer.sv
// ----------------------------------------------------------------------------
// drive_command_can_framer
// turns one control tick into a mode frame 0x156 and a value frame 0x157
// ----------------------------------------------------------------------------
// Input channel s_*: one beat per control tick with steering, acceleration,
// gear, indicator and vehicle status. Output channel m_*: two beats per tick,
// the mode frame first (m_last low), then the value frame (m_last high).
// The accepted beat sits in an input register; once the output is empty or
// its value frame leaves, an edge computes both frames, updates the steering
// filter and the alive counter, and loads the frame pair register, from
// which the mode frame is offered. A new tick is taken while the frames
// of the previous one are still being sent. The filter multiply and the
// clamps run combinationally between input register and frame pair register.
// If the receiver stalls, the current frame holds and the input register
// fills, after which s_ready drops. Synchronous reset clears the filter,
// the alive counter and all valids, and restores the register defaults.
// Registers are to be written through cfg_wen/cfg_idx/cfg_wdata while idle;
// the user must keep to this, the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_command_can_framer #(
    parameter int FILTER_FRAC_BITS = dccf_pkg::FILTER_FRAC_BITS
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               cfg_wen,
    input  wire logic [1:0]         cfg_idx,
    input  wire logic [15:0]        cfg_wdata,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [10:0] s_steering_deg,
    input  wire logic signed [10:0] s_target_accel_centi,
    input  wire logic               s_remote_flag,
    input  wire logic [3:0]         s_gear_code,
    input  wire logic [2:0]         s_indicator,
    input  wire logic [3:0]         s_vehicle_gear,
    input  wire logic [15:0]        s_vehicle_speed,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [10:0]             m_can_id,
    output logic [3:0]              m_length,
    output logic [7:0]              m_data_0,
    output logic [7:0]              m_data_1,
    output logic [7:0]              m_data_2,
    output logic [7:0]              m_data_3,
    output logic [7:0]              m_data_4,
    output logic [7:0]              m_data_5,
    output logic [7:0]              m_data_6,
    output logic [7:0]              m_data_7,
    output logic                    m_last
);

    typedef enum logic [2:0] {
        OUT_EMPTY = 3'b001,
        OUT_MODE  = 3'b010,
        OUT_VALUE = 3'b100
    } out_state_t;

    // configuration
    logic [15:0]        alpha_reg;
    logic signed [10:0] accel_max_reg;
    logic signed [10:0] accel_min_reg;
    logic [7:0]         speed_lvl_reg;

    // input register
    logic               in_valid_reg;
    logic signed [10:0] steer_reg;
    logic signed [10:0] accel_reg;
    logic               remote_reg;
    logic [3:0]         gear_reg;
    logic [2:0]         ind_reg;
    logic [3:0]         vgear_reg;
    logic [15:0]        vspeed_reg;

    out_state_t         state_reg;
    out_state_t         state_next;
    dccf_pkg::frame_pair_t pair_reg;
    dccf_pkg::frame_pair_t pair_next;
    logic [7:0]         alive_reg;

    logic               load;
    logic               s_fire;
    logic signed [10:0] a_sel;
    logic signed [10:0] a_hi;
    logic signed [10:0] a_lim;
    logic [15:0]        steer_x10;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg     <= dccf_pkg::ALPHA_RESET;
            accel_max_reg <= dccf_pkg::ACCEL_MAX_RESET;
            accel_min_reg <= dccf_pkg::ACCEL_MIN_RESET;
            speed_lvl_reg <= dccf_pkg::SPEED_LVL_RESET;
        end else if (cfg_wen) begin
            unique case (dccf_pkg::reg_idx_t'(cfg_idx))
                dccf_pkg::REG_FILTER_ALPHA: alpha_reg     <= cfg_wdata;
                dccf_pkg::REG_ACCEL_MAX:    accel_max_reg <= cfg_wdata[10:0];
                dccf_pkg::REG_ACCEL_MIN:    accel_min_reg <= cfg_wdata[10:0];
                dccf_pkg::REG_SPEED_LEVEL:  speed_lvl_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // new pair loads when the output is empty or the value frame leaves now
    assign load    = in_valid_reg &&
                     ((state_reg == OUT_EMPTY) || ((state_reg == OUT_VALUE) && m_ready));
    assign s_ready = !in_valid_reg || load;
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (load) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            steer_reg  <= s_steering_deg;
            accel_reg  <= s_target_accel_centi;
            remote_reg <= s_remote_flag;
            gear_reg   <= s_gear_code;
            ind_reg    <= s_indicator;
            vgear_reg  <= s_vehicle_gear;
            vspeed_reg <= s_vehicle_speed;
        end
    end

    // acceleration: gear gate, standstill gate, then max and min clamps
    always_comb begin
        if ((vgear_reg == 4'd0) || (vgear_reg == 4'd2)) begin
            a_sel = '0;
        end else if ((vspeed_reg == 16'd0) && accel_reg[10]) begin
            a_sel = '0;
        end else begin
            a_sel = accel_reg;
        end
        a_hi  = (a_sel > accel_max_reg) ? accel_max_reg : a_sel;
        a_lim = (a_hi < accel_min_reg) ? accel_min_reg : a_hi;
    end

    always_comb begin
        pair_next.remote      = remote_reg;
        pair_next.speed_level = speed_lvl_reg;
        pair_next.gear_ind    = {gear_reg, 1'b0, ind_reg};
        pair_next.alive       = alive_reg;
        pair_next.accel16     = {{5{a_lim[10]}}, a_lim} + dccf_pkg::ACCEL_OFFSET;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pair_reg <= pair_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alive_reg <= '0;
        end else if (load) begin
            alive_reg <= alive_reg + 8'd1;
        end
    end

    // filter value stays put while this tick's value frame is pending
    dccf_lpf #(
        .FRAC_BITS (FILTER_FRAC_BITS)
    ) u_lpf (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (load),
        .steering_deg (steer_reg),
        .filter_alpha (alpha_reg),
        .steer_x10    (steer_x10)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            OUT_EMPTY: begin
                if (load) begin
                    state_next = OUT_MODE;
                end
            end
            OUT_MODE: begin
                if (m_ready) begin
                    state_next = OUT_VALUE;
                end
            end
            OUT_VALUE: begin
                if (m_ready) begin
                    state_next = load ? OUT_MODE : OUT_EMPTY;
                end
            end
            default: state_next = OUT_EMPTY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= OUT_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

    assign m_valid = (state_reg != OUT_EMPTY);
    assign m_last  = (state_reg == OUT_VALUE);

    always_comb begin
        if (m_last) begin
            m_can_id = dccf_pkg::VALUE_ID;
            m_length = dccf_pkg::VALUE_LEN;
            m_data_0 = steer_x10[7:0];
            m_data_1 = steer_x10[15:8];
            m_data_2 = 8'd0;
            m_data_3 = pair_reg.accel16[7:0];
            m_data_4 = pair_reg.accel16[15:8];
            m_data_5 = 8'd0;
            m_data_6 = 8'd0;
            m_data_7 = 8'd0;
        end else begin
            m_can_id = dccf_pkg::MODE_ID;
            m_length = dccf_pkg::MODE_LEN;
            m_data_0 = {7'd0, pair_reg.remote};
            m_data_1 = pair_reg.speed_level;
            m_data_2 = {7'd0, pair_reg.remote};
            m_data_3 = 8'd0;
            m_data_4 = 8'd0;
            m_data_5 = pair_reg.gear_ind;
            m_data_6 = 8'd0;
            m_data_7 = pair_reg.alive;
        end
    end

endmodule

`default_nettype wire

### design/dccf_checker.sv
// ----------------------------------------------------------------------------
// dccf_checker
// port-level checks on the frame sequence of the drive command can framer
// ----------------------------------------------------------------------------
`default_nettype none

`include "drive_command_can_framer_defines.svh"

module dccf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [10:0] m_can_id,
    input wire logic [3:0]  m_length,
    input wire logic [7:0]  m_data_0,
    input wire logic [7:0]  m_data_2,
    input wire logic [7:0]  m_data_3,
    input wire logic [7:0]  m_data_5,
    input wire logic [7:0]  m_data_6,
    input wire logic [7:0]  m_data_7,
    input wire logic        m_last
);

    // a mode frame beat is always followed by its value frame
    `DCCF_ASSERT_NEXT(a_mode_then_value, aclk, aresetn, m_valid && m_ready && !m_last, m_valid && m_last)

    `DCCF_ASSERT_NOW(a_mode_header, aclk, aresetn, m_valid && !m_last, (m_can_id == dccf_pkg::MODE_ID) && (m_length == dccf_pkg::MODE_LEN))

    `DCCF_ASSERT_NOW(a_value_frame, aclk, aresetn, m_valid && m_last, (m_can_id == dccf_pkg::VALUE_ID) && (m_length == dccf_pkg::VALUE_LEN) && (m_data_2 == 8'd0) && (m_data_5 == 8'd0) && (m_data_6 == 8'd0) && (m_data_7 == 8'd0))

    `DCCF_ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_last) && $stable(m_data_0) && $stable(m_data_3))

endmodule

bind drive_command_can_framer dccf_checker u_dccf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_can_id (m_can_id),
    .m_length (m_length),
    .m_data_0 (m_data_0),
    .m_data_2 (m_data_2),
    .m_data_3 (m_data_3),
    .m_data_5 (m_data_5),
    .m_data_6 (m_data_6),
    .m_data_7 (m_data_7),
    .m_last   (m_last)
);

`default_nettype wire
